[hw/rtl/irws_pkg.sv]
// Shared types and constants for the IR wall sensing / lateral PID core.
// No dependencies; used by the core, irws_interp and irws_pid.
package irws_pkg;

  // Work carried down the pipeline with each request
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RIGHT,
    OP_LEFT,
    OP_PID_RUN,
    OP_PID_CLEAR
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_GAIN_P = 2'd1;
  localparam logic [1:0] CFG_GAIN_I = 2'd2;
  localparam logic [1:0] CFG_GAIN_D = 2'd3;

  // Sequence phases with work attached
  localparam int unsigned PH_EMIT_A = 0;
  localparam int unsigned PH_RIGHT  = 2;
  localparam int unsigned PH_LEFT   = 4;
  localparam int unsigned PH_EVAL   = 5;

  // Flag byte
  localparam logic [7:0] FLAGS_RESET = 8'h04;
  localparam logic [7:0] FLAGS_START = 8'h11;
  localparam logic [7:0] FLAG_R_NEAR = 8'h02;
  localparam logic [7:0] FLAG_R_FAR  = 8'h20;
  localparam logic [7:0] FLAG_L_NEAR = 8'h08;
  localparam logic [7:0] FLAG_L_FAR  = 8'h80;
  localparam logic [7:0] MASK_FRONT  = 8'hFE;
  localparam logic [7:0] MASK_CROSS  = 8'hEF;

  // ADC thresholds
  localparam logic [11:0] SIDE_NEAR   = 12'd100;
  localparam logic [11:0] SIDE_FAR    = 12'd200;
  localparam logic [11:0] SAMPLE_FLOOR = 12'd150;
  localparam logic [11:0] FRONT_WALL  = 12'd200;
  localparam logic [11:0] FL_CROSS    = 12'd680;
  localparam logic [11:0] FR_CROSS    = 12'd760;

  // Interpolation: 14-count segments, x/14 as (x*4682)>>16 (exact below 4096)
  localparam logic [3:0]  SEG_LEN       = 4'd14;
  localparam logic [12:0] RECIP14       = 13'd4682;

  // Lateral error
  localparam logic signed [9:0] CENTRE_MM = 10'sd84;
  localparam logic signed [9:0] DEADBAND  = 10'sd3;
  localparam logic signed [9:0] ERR_CLAMP = 10'sd30;

  // x/10 as (x*838861)>>23, exact below 2^18
  localparam logic [19:0] RECIP10 = 20'd838861;

  typedef struct packed {
    logic [9:0] p;
    logic [9:0] i;
    logic [9:0] d;
  } gains_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] emit;   // bit0 emitter A, bit1 emitter B
    logic [7:0] flags;
    logic       lw;     // left wall seen in last latch
    logic       rw;     // right wall seen in last latch
  } tick_info_t;

  typedef struct packed {
    tick_info_t  info;
    logic [11:0] sample;
  } interp_in_t;

  typedef struct packed {
    tick_info_t info;
    logic [7:0] left;
    logic [7:0] right;
  } side_out_t;

  typedef struct packed {
    logic [1:0]         emit;
    logic [7:0]         flags;
    logic [7:0]         left;
    logic [7:0]         right;
    logic signed [15:0] corr;
    logic               valid;
  } result_t;

endpackage

[hw/rtl/ir_wall_sense_lateral_pid_core.sv]
// IR wall sensing with lateral PID correction: top level.
// One request per cycle sustained while m_tready is high, set by the
// ripple-ready pipeline around the dual-read distance table RAM.
// Synchronous active-high reset clears phase, drives, flags (0x04), distances,
// PID state and gains; table RAM contents are undefined until written.
// Depends on irws_pkg, irws_interp, irws_pid, irws_ram.
module ir_wall_sense_lateral_pid_core #(
  parameter int TABLE_DEPTH = 512,
  parameter int PHASE_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // adc_ch0[11:0] adc_ch1[23:12] adc_ch2[35:24] adc_ch3[47:36]
  // table_select[48] table_index[57:49] table_value[65:58], zero pad to 72
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,    // req_type: 0 sensing tick, 1 table write
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // emitter_a_on[0] emitter_b_on[1] crossway_flags[9:2] left_distance[17:10]
  // right_distance[25:18] motor_correction[41:26], zero pad to 48
  output logic [47:0] m_tdata,
  output logic        m_tuser     // correction_valid
);

  localparam int PW = $clog2(PHASE_COUNT);
  localparam int IW = $clog2(TABLE_DEPTH);

  // Unpack request
  logic        req_type;
  logic [11:0] adc_ch0, adc_ch1, adc_ch2, adc_ch3;
  logic        table_select;
  logic [8:0]  table_index;
  logic [7:0]  table_value;

  assign req_type     = s_tuser;
  assign adc_ch0      = s_tdata[11:0];
  assign adc_ch1      = s_tdata[23:12];
  assign adc_ch2      = s_tdata[35:24];
  assign adc_ch3      = s_tdata[47:36];
  assign table_select = s_tdata[48];
  assign table_index  = s_tdata[57:49];
  assign table_value  = s_tdata[65:58];

  // Configuration registers
  logic            correction_enable;
  irws_pkg::gains_t gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      correction_enable <= 1'b0;
      gains             <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        irws_pkg::CFG_ENABLE: correction_enable <= cfg_data[0];
        irws_pkg::CFG_GAIN_P: gains.p <= cfg_data;
        irws_pkg::CFG_GAIN_I: gains.i <= cfg_data;
        irws_pkg::CFG_GAIN_D: gains.d <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state, updated as each sensing tick is taken in
  logic [PW-1:0] phase, phase_next;
  logic [1:0]    emit, emit_next;
  logic [7:0]    flags_new, flags_new_next;   // byte being built this sequence
  logic [7:0]    flags_done, flags_done_next; // latest completed byte
  logic [11:0]   lat_fl, lat_fl_next;         // latched front-left
  logic [11:0]   lat_fr, lat_fr_next;         // latched front-right
  logic          lw, lw_next, rw, rw_next;    // side walls at last latch
  logic [11:0]   side_sample;
  irws_pkg::op_t op;

  logic accept, tick;
  assign accept = s_tvalid && s_tready;
  assign tick   = accept && !req_type;

  always_comb begin
    phase_next      = (phase == PW'(PHASE_COUNT - 1)) ? '0 : phase + PW'(1);
    emit_next       = emit;
    flags_new_next  = flags_new;
    flags_done_next = flags_done;
    lat_fl_next     = lat_fl;
    lat_fr_next     = lat_fr;
    lw_next         = lw;
    rw_next         = rw;
    side_sample     = adc_ch2;
    op              = irws_pkg::OP_NONE;

    if (req_type) begin
      phase_next = phase;
    end else if (phase == PW'(irws_pkg::PH_EMIT_A)) begin
      emit_next[0]   = 1'b1;
      flags_new_next = irws_pkg::FLAGS_START;
    end else if (phase == PW'(irws_pkg::PH_RIGHT)) begin
      // front-left and right side latched, emitter B takes over
      lat_fl_next = adc_ch0;
      rw_next     = (adc_ch2 >= irws_pkg::SAMPLE_FLOOR);
      emit_next   = 2'b10;
      if (adc_ch2 <= irws_pkg::SIDE_NEAR) flags_new_next = flags_new_next | irws_pkg::FLAG_R_NEAR;
      if (adc_ch2 <= irws_pkg::SIDE_FAR)  flags_new_next = flags_new_next | irws_pkg::FLAG_R_FAR;
      op = irws_pkg::OP_RIGHT;
    end else if (phase == PW'(irws_pkg::PH_LEFT)) begin
      lat_fr_next  = adc_ch3;
      lw_next      = (adc_ch1 >= irws_pkg::SAMPLE_FLOOR);
      emit_next[1] = 1'b0;
      if (adc_ch1 <= irws_pkg::SIDE_NEAR) flags_new_next = flags_new_next | irws_pkg::FLAG_L_NEAR;
      if (adc_ch1 <= irws_pkg::SIDE_FAR)  flags_new_next = flags_new_next | irws_pkg::FLAG_L_FAR;
      side_sample = adc_ch1;
      op          = irws_pkg::OP_LEFT;
    end else if (phase == PW'(irws_pkg::PH_EVAL)) begin
      // front walls clear the open-ahead bits, then the byte is published
      if (lat_fl >= irws_pkg::FRONT_WALL || lat_fr >= irws_pkg::FRONT_WALL)
        flags_new_next = flags_new_next & irws_pkg::MASK_FRONT;
      if (lat_fl >= irws_pkg::FL_CROSS || lat_fr >= irws_pkg::FR_CROSS)
        flags_new_next = flags_new_next & irws_pkg::MASK_CROSS;
      flags_done_next = flags_new_next;
      op = correction_enable ? irws_pkg::OP_PID_RUN : irws_pkg::OP_PID_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      emit       <= 2'b00;
      flags_new  <= irws_pkg::FLAGS_RESET;
      flags_done <= irws_pkg::FLAGS_RESET;
      lat_fl     <= 12'd0;
      lat_fr     <= 12'd0;
      lw         <= 1'b0;
      rw         <= 1'b0;
    end else if (tick) begin
      phase      <= phase_next;
      emit       <= emit_next;
      flags_new  <= flags_new_next;
      flags_done <= flags_done_next;
      lat_fl     <= lat_fl_next;
      lat_fr     <= lat_fr_next;
      lw         <= lw_next;
      rw         <= rw_next;
    end
  end

  // Request into the lookup pipeline; a table write rides through as a no-op
  irws_pkg::interp_in_t interp_in;

  always_comb begin
    interp_in.info.op    = op;
    interp_in.info.emit  = req_type ? emit       : emit_next;
    interp_in.info.flags = req_type ? flags_done : flags_done_next;
    interp_in.info.lw    = lw;
    interp_in.info.rw    = rw;
    interp_in.sample     = side_sample;
  end

  // Table write: side selects the upper half, out-of-range index dropped
  logic          wr_en;
  logic [IW:0]   wr_addr;

  assign wr_en   = accept && req_type && (11'(table_index) < 11'(TABLE_DEPTH));
  assign wr_addr = {table_select, IW'(table_index)};

  logic                 side_valid, side_ready;
  irws_pkg::side_out_t  side_item;

  irws_interp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (table_value),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (interp_in),
    .out_valid (side_valid),
    .out_ready (side_ready),
    .out_item  (side_item)
  );

  irws_pkg::result_t res;

  irws_pid u_pid (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .in_valid  (side_valid),
    .in_ready  (side_ready),
    .in_item   (side_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res)
  );

  assign m_tdata = {6'd0, res.corr, res.right, res.left, res.flags, res.emit};
  assign m_tuser = res.valid;

endmodule

[hw/rtl/irws_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module irws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[hw/rtl/irws_interp.sv]
// Distance lookup: table RAM, interpolation pipeline and side distance state.
// Depends on irws_pkg and irws_ram.
module irws_interp #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(TABLE_DEPTH):0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  irws_pkg::interp_in_t         in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output irws_pkg::side_out_t          out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [10:0] LAST_IDX = 11'(TABLE_DEPTH - 1);

  // segment and fraction from the incoming sample
  logic [11:0] offs;
  logic [24:0] seg_prod;
  logic [8:0]  seg;
  logic [11:0] seg_base;
  logic [3:0]  frac;
  logic [10:0] ka, kb, ka_c, kb_c;
  logic        side;

  assign offs     = in_item.sample - irws_pkg::SAMPLE_FLOOR;
  assign seg_prod = 25'(offs) * 25'(irws_pkg::RECIP14);
  assign seg      = seg_prod[24:16];
  assign seg_base = 12'(seg) * 12'(irws_pkg::SEG_LEN);
  assign frac     = 4'(offs - seg_base);
  assign ka       = 11'(seg);
  assign kb       = 11'(seg) + 11'd1;
  assign ka_c     = (ka > LAST_IDX) ? LAST_IDX : ka;
  assign kb_c     = (kb > LAST_IDX) ? LAST_IDX : kb;
  assign side     = (in_item.info.op == irws_pkg::OP_RIGHT);

  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic [7:0] tab_a, tab_b;

  irws_ram #(
    .WIDTH (8),
    .DEPTH (2 * (2 ** IW))
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (en1),
    .raddr_a ({side, ka_c[IW-1:0]}),
    .raddr_b ({side, kb_c[IW-1:0]}),
    .rdata_a (tab_a),
    .rdata_b (tab_b)
  );

  // stage 1: RAM data, stage 2: weighted sum, stage 3: /14 and side update
  irws_pkg::interp_in_t s1_item, s2_item;
  logic [3:0]  s1_frac;
  logic [11:0] s2_x;
  logic [11:0] wsum;
  logic [24:0] q_prod;
  logic [7:0]  q;
  logic        lookup;
  logic [7:0]  left, right, left_next, right_next;

  assign wsum   = 12'(tab_a) * 12'(s1_frac)
                + 12'(tab_b) * 12'(irws_pkg::SEG_LEN - s1_frac);
  assign q_prod = 25'(s2_x) * 25'(irws_pkg::RECIP14);
  assign q      = q_prod[23:16];
  assign lookup = (s2_item.sample >= irws_pkg::SAMPLE_FLOOR);

  always_comb begin
    left_next  = left;
    right_next = right;
    case (s2_item.info.op)
      irws_pkg::OP_RIGHT: right_next = lookup ? q : left;
      irws_pkg::OP_LEFT:  left_next  = lookup ? q : right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      left  <= 8'd0;
      right <= 8'd0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en3 && v2) begin
        left  <= left_next;
        right <= right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_item <= in_item;
      s1_frac <= frac;
    end
    if (en2) begin
      s2_item <= s1_item;
      s2_x    <= wsum;
    end
    if (en3) begin
      out_item.info  <= s2_item.info;
      out_item.left  <= left_next;
      out_item.right <= right_next;
    end
  end

  assign out_valid = v3;

endmodule

[hw/rtl/irws_pid.sv]
// Lateral error and incremental PID pipeline with saturating accumulator.
// Depends on irws_pkg.
module irws_pid (
  input  logic                clk,
  input  logic                rst,
  input  irws_pkg::gains_t    gains,
  input  logic                in_valid,
  output logic                in_ready,
  input  irws_pkg::side_out_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output irws_pkg::result_t   out_item
);

  logic v4, v5, v6, v7, v8;
  logic en4, en5, en6, en7, en8;

  assign en8      = !v8 || out_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  // stage 4: error and history
  logic signed [6:0] lat_err, e0, e1, e2;
  logic signed [6:0] e0_next, e1_next, e2_next, lat_next;
  logic signed [9:0] l10, r10, diff, half, e_raw, e_cl;

  assign l10  = $signed({2'b00, in_item.left});
  assign r10  = $signed({2'b00, in_item.right});
  assign diff = l10 - r10;
  assign half = (diff + $signed(10'(diff[9]))) >>> 1;

  always_comb begin
    if (in_item.info.lw && in_item.info.rw) e_raw = half;
    else if (in_item.info.lw)               e_raw = l10 - irws_pkg::CENTRE_MM;
    else if (in_item.info.rw)               e_raw = irws_pkg::CENTRE_MM - r10;
    else                                    e_raw = 10'(lat_err);
    if (e_raw > -irws_pkg::DEADBAND && e_raw < irws_pkg::DEADBAND) e_cl = 10'sd0;
    else if (e_raw > irws_pkg::ERR_CLAMP)  e_cl = irws_pkg::ERR_CLAMP;
    else if (e_raw < -irws_pkg::ERR_CLAMP) e_cl = -irws_pkg::ERR_CLAMP;
    else                                   e_cl = e_raw;

    lat_next = lat_err;
    e0_next  = e0;
    e1_next  = e1;
    e2_next  = e2;
    case (in_item.info.op)
      irws_pkg::OP_PID_RUN: begin
        lat_next = 7'(e_cl);
        e0_next  = 7'(e_cl);
        e1_next  = e0;
        e2_next  = e1;
      end
      irws_pkg::OP_PID_CLEAR: begin
        lat_next = 7'sd0;
        e0_next  = 7'sd0;
        e1_next  = 7'sd0;
        e2_next  = 7'sd0;
      end
      default: ;
    endcase
  end

  irws_pkg::result_t s4_res, s5_res, s6_res, s7_res;
  irws_pkg::op_t     s4_op, s5_op, s6_op, s7_op;
  logic signed [6:0] s4_e0, s4_e1, s4_e2;

  // stage 5: gain products
  logic signed [8:0]  dp, dd;
  logic signed [19:0] gp, gi, gd;
  logic signed [19:0] s5_pp, s5_pi, s5_pd;

  assign dp = 9'(s4_e0) - 9'(s4_e1);
  assign dd = 9'(s4_e0) - (9'(s4_e1) <<< 1) + 9'(s4_e2);
  assign gp = $signed(20'({1'b0, gains.p})) * 20'(dp);
  assign gi = $signed(20'({1'b0, gains.i})) * 20'(s4_e0);
  assign gd = $signed(20'({1'b0, gains.d})) * 20'(dd);

  // stage 6: sum and magnitude
  logic signed [20:0] psum;
  logic [20:0]        pabs;
  logic               s6_neg;
  logic [17:0]        s6_mag;

  assign psum = 21'(s5_pp) + 21'(s5_pi) + 21'(s5_pd);
  assign pabs = psum[20] ? 21'(-psum) : 21'(psum);

  // stage 7: /10 by reciprocal
  logic [37:0] q_prod;
  logic        s7_neg;
  logic [14:0] s7_q;

  assign q_prod = 38'(s6_mag) * 38'(irws_pkg::RECIP10);

  // stage 8: accumulate with saturation
  logic signed [15:0] acc, acc_next;
  logic signed [16:0] delta, acc_sum;
  irws_pkg::result_t  res_next;

  assign delta   = s7_neg ? -$signed({2'b00, s7_q}) : $signed({2'b00, s7_q});
  assign acc_sum = 17'(acc) + delta;

  always_comb begin
    case (s7_op)
      irws_pkg::OP_PID_RUN: begin
        if (acc_sum > 17'sd32767)        acc_next = 16'sh7FFF;
        else if (acc_sum < -17'sd32768)  acc_next = 16'sh8000;
        else                             acc_next = 16'(acc_sum);
      end
      irws_pkg::OP_PID_CLEAR: acc_next = 16'sd0;
      default:                acc_next = acc;
    endcase
  end

  always_comb begin
    res_next      = s7_res;
    res_next.corr = acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4      <= 1'b0;
      v5      <= 1'b0;
      v6      <= 1'b0;
      v7      <= 1'b0;
      v8      <= 1'b0;
      lat_err <= 7'sd0;
      e0      <= 7'sd0;
      e1      <= 7'sd0;
      e2      <= 7'sd0;
      acc     <= 16'sd0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en4 && in_valid) begin
        lat_err <= lat_next;
        e0      <= e0_next;
        e1      <= e1_next;
        e2      <= e2_next;
      end
      if (en8 && v7) acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_op        <= in_item.info.op;
      s4_res.emit  <= in_item.info.emit;
      s4_res.flags <= in_item.info.flags;
      s4_res.left  <= in_item.left;
      s4_res.right <= in_item.right;
      s4_res.corr  <= 16'sd0;
      s4_res.valid <= (in_item.info.op == irws_pkg::OP_PID_RUN);
      s4_e0        <= e0_next;
      s4_e1        <= e1_next;
      s4_e2        <= e2_next;
    end
    if (en5) begin
      s5_op  <= s4_op;
      s5_res <= s4_res;
      s5_pp  <= gp;
      s5_pi  <= gi;
      s5_pd  <= gd;
    end
    if (en6) begin
      s6_op  <= s5_op;
      s6_res <= s5_res;
      s6_neg <= psum[20];
      s6_mag <= pabs[17:0];
    end
    if (en7) begin
      s7_op  <= s6_op;
      s7_res <= s6_res;
      s7_neg <= s6_neg;
      s7_q   <= q_prod[37:23];
    end
    if (en8) begin
      out_item <= res_next;
    end
  end

  assign out_valid = v8;

endmodule
